/* rtl/ttc_pkg.sv */
`timescale 1ns / 1ps

package ttc_pkg;

    typedef logic signed [15:0] t_temp;
    typedef logic [9:0]         t_reading;

    // Register indexes, word address bits [4:2]
    localparam logic [2:0] REG_SAMPLE_COUNT = 3'd0;
    localparam logic [2:0] REG_SERIES_RES   = 3'd1;
    localparam logic [2:0] REG_COEFF_A      = 3'd2;
    localparam logic [2:0] REG_COEFF_B      = 3'd3;
    localparam logic [2:0] REG_COEFF_C      = 3'd4;
    localparam logic [2:0] REG_PULL_UP      = 3'd5;
    localparam logic [2:0] REG_TEMP_OFFSET  = 3'd6;
    localparam logic [2:0] REG_OUTPUT_UNIT  = 3'd7;

    localparam logic [1:0] UNIT_KELVIN     = 2'd0;
    localparam logic [1:0] UNIT_CELSIUS    = 2'd1;
    localparam logic [1:0] UNIT_FAHRENHEIT = 2'd2;

    // ln2 in Q30, 0 degC in kelvin Q11, kelvin cap, Fahrenheit bias (32 F plus rounding)
    localparam logic [29:0]        LN2_Q30       = 30'd744261118;
    localparam logic signed [63:0] KELVIN_0C_Q11 = 64'sd559411;
    localparam logic [63:0]        K_CAP         = 64'h0000_0100_0000_0000;
    localparam logic signed [63:0] F_BIAS        = 64'sd328000;
    localparam logic [63:0]        DIV_TOP       = 64'h8000_0000_0000_0000;

    localparam int LN_FRAC_BITS = 28;
    localparam int LN_ARG_BITS  = 20;

endpackage

/* rtl/ttc_channels.sv */
`timescale 1ns / 1ps

interface ttc_in_if;
    logic               valid;
    logic               ready;
    ttc_pkg::t_reading  adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

interface ttc_out_if;
    logic               valid;
    logic               ready;
    ttc_pkg::t_temp     temperature;
    ttc_pkg::t_reading  averaged_reading;
    logic               fault;

    modport source (output valid, output temperature, output averaged_reading,
                    output fault, input ready);
    modport sink   (input valid, input temperature, input averaged_reading,
                    input fault, output ready);
endinterface

/* rtl/thermistor_temperature_converter_top.sv */
// Sample transfer that does not close a window: the block stays idle, next sample accepted next cycle.
// Closing sample: conversion time set by the bit-serial multiplier (28 squarings per log,
// three logs) and the restoring divider.
// One window in flight; a finished result waits in the output register while samples flow.
// Reset (i_rst_n low, synchronous): registers to defaults, window cleared, no result pending.
`timescale 1ns / 1ps

module thermistor_temperature_converter_top #(
    parameter int ADC_BITS   = 10,
    parameter int MAX_WINDOW = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ttc_in_if.sink      i_in,
    ttc_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int NW = (CW > 7) ? CW : 7;
    localparam int SW = ADC_BITS + CW;
    localparam int XW = ttc_pkg::LN_ARG_BITS;
    localparam logic [XW-1:0] FULL_SCALE = XW'(1) << ADC_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_AVG, S_NORM, S_SQ, S_SCALE, S_L2, S_L3,
        S_BL, S_CL, S_KDIV, S_UNIT, S_FDIV, S_OUT
    } t_state;

    // configuration registers
    logic [6:0]         r_sample_count;
    logic [19:0]        r_series_res;
    logic signed [31:0] r_coeff_a;
    logic signed [31:0] r_coeff_b;
    logic signed [31:0] r_coeff_c;
    logic               r_pull_up;
    logic signed [12:0] r_temp_offset;
    logic [1:0]         r_output_unit;

    // window and sequencer
    logic [SW-1:0]       r_sum;
    logic [CW-1:0]       r_taken;
    t_state              r_state;
    logic                r_go;
    logic [ADC_BITS-1:0] r_avg;
    logic                r_fault;
    logic [1:0]          r_sel;
    logic [30:0]         r_m;
    logic [4:0]          r_kexp;
    logic [27:0]         r_frac;
    logic [4:0]          r_it;
    logic [29:0]         r_ln_rs;
    logic [29:0]         r_ln_a;
    logic signed [31:0]  r_l;
    logic signed [63:0]  r_l2;
    logic signed [32:0]  r_l3;
    logic signed [63:0]  r_y;
    logic signed [63:0]  r_k;
    logic signed [63:0]  r_t;
    logic signed [63:0]  r_fq;
    logic                r_fneg;

    // bit-serial multiplier
    logic [63:0] r_ma;
    logic [63:0] r_mh;
    logic [31:0] r_ml;
    logic        r_mneg;
    logic [4:0]  r_mcnt;
    logic        r_mbusy;
    logic        r_mdone;

    // restoring divider
    logic [63:0] r_dq;
    logic [63:0] r_dr;
    logic [63:0] r_dd;
    logic [5:0]  r_dcnt;
    logic        r_dbusy;
    logic        r_ddone;

    // output register
    logic               r_out_valid;
    ttc_pkg::t_temp     r_out_temp;
    ttc_pkg::t_reading  r_out_avg;
    logic               r_out_fault;

    // ---------------------------------------------------------------------
    // Configuration port: write at the access phase, read back combinationally
    // ---------------------------------------------------------------------
    logic cfg_we;
    assign cfg_we = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        case (paddr[4:2])
            ttc_pkg::REG_SAMPLE_COUNT: prdata = 32'(r_sample_count);
            ttc_pkg::REG_SERIES_RES:   prdata = 32'(r_series_res);
            ttc_pkg::REG_COEFF_A:      prdata = r_coeff_a;
            ttc_pkg::REG_COEFF_B:      prdata = r_coeff_b;
            ttc_pkg::REG_COEFF_C:      prdata = r_coeff_c;
            ttc_pkg::REG_PULL_UP:      prdata = 32'(r_pull_up);
            ttc_pkg::REG_TEMP_OFFSET:  prdata = 32'(r_temp_offset);
            ttc_pkg::REG_OUTPUT_UNIT:  prdata = 32'(r_output_unit);
            default:                   prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Window accumulation
    // ---------------------------------------------------------------------
    logic [SW-1:0] sample_ext;
    logic [SW-1:0] sum_new;
    logic [CW-1:0] taken_new;
    logic [NW-1:0] n_eff;
    logic          win_close;
    logic          accept;

    assign sample_ext = SW'(ADC_BITS'(i_in.adc_sample));
    assign sum_new    = r_sum + sample_ext;
    assign taken_new  = r_taken + CW'(1);
    // a zero window counts as one, an oversized one as the maximum
    assign n_eff = (r_sample_count == 7'd0) ? NW'(1) :
                   (NW'(r_sample_count) > NW'(MAX_WINDOW)) ? NW'(MAX_WINDOW) :
                   NW'(r_sample_count);
    assign win_close = (NW'(taken_new) >= n_eff);
    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;

    // ---------------------------------------------------------------------
    // Operand selection for the shared multiplier and divider
    // ---------------------------------------------------------------------
    logic               mul_start;
    logic signed [63:0] mul_a;
    logic signed [32:0] mul_b;
    logic [63:0]        mag_a;
    logic [31:0]        mag_b;
    logic               div_start;
    logic [63:0]        div_n;
    logic [63:0]        div_d;
    logic [63:0]        y_mag;

    assign y_mag = r_y[63] ? 64'(-r_y) : 64'(r_y);

    always_comb begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_n     = '0;
        div_d     = 64'd1;
        case (r_state)
            S_AVG: begin
                div_start = r_go;
                div_n     = 64'(r_sum);
                div_d     = 64'(r_taken);
            end
            S_SQ: begin
                mul_start = r_go;
                mul_a     = $signed(64'(r_m));
                mul_b     = $signed({2'b00, r_m});
            end
            S_SCALE: begin
                mul_start = r_go;
                mul_a     = $signed(64'({r_kexp, r_frac}));
                mul_b     = $signed({3'b000, ttc_pkg::LN2_Q30});
            end
            S_L2: begin
                mul_start = r_go;
                mul_a     = 64'(r_l);
                mul_b     = 33'(r_l);
            end
            S_L3: begin
                mul_start = r_go;
                mul_a     = r_l2;
                mul_b     = 33'(r_l);
            end
            S_BL: begin
                mul_start = r_go;
                mul_a     = 64'(r_coeff_b);
                mul_b     = 33'(r_l);
            end
            S_CL: begin
                mul_start = r_go;
                mul_a     = 64'(r_coeff_c);
                mul_b     = r_l3;
            end
            S_KDIV: begin
                div_start = r_go;
                div_n     = ttc_pkg::DIV_TOP;
                div_d     = y_mag;
            end
            S_FDIV: begin
                div_start = r_go;
                div_n     = 64'(r_fq);
                div_d     = 64'd5;
            end
            default: ;
        endcase
    end

    assign mag_a = mul_a[63] ? 64'(-mul_a) : 64'(mul_a);
    assign mag_b = mul_b[32] ? 32'(-mul_b) : 32'(mul_b);

    // one add of the multiplicand per multiplier bit
    logic [64:0]        m_sum;
    logic [95:0]        prod_u;
    logic signed [96:0] mul_p;

    assign m_sum  = {1'b0, r_mh} + (r_ml[0] ? {1'b0, r_ma} : 65'd0);
    assign prod_u = {r_mh, r_ml};
    assign mul_p  = r_mneg ? -$signed({1'b0, prod_u}) : $signed({1'b0, prod_u});

    // one quotient bit per cycle
    logic [64:0] d_sh;
    logic [65:0] d_diff;
    logic        d_ge;

    assign d_sh   = {r_dr, r_dq[63]};
    assign d_diff = {1'b0, d_sh} - {2'b00, r_dd};
    assign d_ge   = !d_diff[65];

    // ---------------------------------------------------------------------
    // Datapath values taken at the end of each step
    // ---------------------------------------------------------------------
    logic               mul_ready;
    logic               div_ready;
    logic [19:0]        rs_eff;
    logic [XW-1:0]      lnb_x;
    logic [31:0]        m2;
    logic [29:0]        ln_new;
    logic signed [31:0] lr;
    logic signed [31:0] la;
    logic signed [31:0] lb;
    logic signed [31:0] l_new;
    logic signed [63:0] a_term;
    logic signed [63:0] y_fin;
    logic signed [63:0] off128;
    logic [63:0]        kmag;
    logic signed [63:0] k_div;
    logic signed [63:0] c_val;
    logic signed [63:0] f_x;
    logic signed [63:0] f_q;
    logic signed [63:0] k_t;
    logic signed [63:0] c_t;
    ttc_pkg::t_temp     t_sat;

    assign mul_ready = !r_go && r_mdone;
    assign div_ready = !r_go && r_ddone;
    // zero ohms counts as one
    assign rs_eff = (r_series_res == 20'd0) ? 20'd1 : r_series_res;
    assign lnb_x  = FULL_SCALE - XW'(r_avg);
    assign m2     = prod_u[61:30];
    assign ln_new = prod_u[63:34];
    assign lr     = $signed({2'b00, r_ln_rs});
    assign la     = $signed({2'b00, r_ln_a});
    assign lb     = $signed({2'b00, ln_new});
    assign l_new  = r_pull_up ? (lr + la - lb) : (lr - la + lb);
    assign a_term = 64'(r_coeff_a) <<< 12;
    assign y_fin  = r_y + 64'(mul_p >>> 28);
    assign off128 = 64'(r_temp_offset) <<< 7;
    assign kmag   = (r_dq > ttc_pkg::K_CAP) ? ttc_pkg::K_CAP : r_dq;
    assign k_div  = (r_y[63] ? -$signed(kmag) : $signed(kmag)) + off128;
    assign c_val  = r_k - ttc_pkg::KELVIN_0C_Q11;
    assign f_x    = (c_val <<< 3) + c_val + ttc_pkg::F_BIAS;
    assign f_q    = f_x >>> 7;
    assign k_t    = (r_k + 64'sd64) >>> 7;
    assign c_t    = (c_val + 64'sd64) >>> 7;
    assign t_sat  = (r_t > 64'sd32767)  ? 16'sh7FFF :
                    (r_t < -64'sd32768) ? 16'sh8000 : r_t[15:0];

    // ---------------------------------------------------------------------
    // Sequencer, arithmetic units and output register
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= 7'd8;
            r_series_res   <= 20'd10000;
            r_coeff_a      <= 32'sd1232407859;
            r_coeff_b      <= 32'sd1035025163;
            r_coeff_c      <= 32'sd1028916;
            r_pull_up      <= 1'b1;
            r_temp_offset  <= '0;
            r_output_unit  <= ttc_pkg::UNIT_KELVIN;
            r_sum          <= '0;
            r_taken        <= '0;
            r_state        <= S_IDLE;
            r_go           <= 1'b0;
            r_mbusy        <= 1'b0;
            r_mdone        <= 1'b0;
            r_dbusy        <= 1'b0;
            r_ddone        <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_go <= 1'b0;

            if (cfg_we) begin
                case (paddr[4:2])
                    ttc_pkg::REG_SAMPLE_COUNT: r_sample_count <= pwdata[6:0];
                    ttc_pkg::REG_SERIES_RES:   r_series_res   <= pwdata[19:0];
                    ttc_pkg::REG_COEFF_A:      r_coeff_a      <= $signed(pwdata);
                    ttc_pkg::REG_COEFF_B:      r_coeff_b      <= $signed(pwdata);
                    ttc_pkg::REG_COEFF_C:      r_coeff_c      <= $signed(pwdata);
                    ttc_pkg::REG_PULL_UP:      r_pull_up      <= pwdata[0];
                    ttc_pkg::REG_TEMP_OFFSET:  r_temp_offset  <= $signed(pwdata[12:0]);
                    ttc_pkg::REG_OUTPUT_UNIT:  r_output_unit  <= pwdata[1:0];
                    default: ;
                endcase
            end

            // drop the result once the sink takes it
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_sum   <= sum_new;
                        r_taken <= taken_new;
                        if (win_close) begin
                            r_state <= S_AVG;
                            r_go    <= 1'b1;
                        end
                    end
                end
                S_AVG: begin
                    if (div_ready) begin
                        r_sum   <= '0;
                        r_taken <= '0;
                        r_avg   <= r_dq[ADC_BITS-1:0];
                        if (r_dq[ADC_BITS-1:0] == '0) begin
                            // empty divider reading: flag it, no conversion
                            r_fault <= 1'b1;
                            r_t     <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_fault <= 1'b0;
                            r_sel   <= 2'd0;
                            r_m     <= 31'(rs_eff);
                            r_kexp  <= 5'd30;
                            r_state <= S_NORM;
                        end
                    end
                end
                S_NORM: begin
                    // shift the log argument up until its top bit is set
                    if (r_m[30]) begin
                        r_it    <= '0;
                        r_frac  <= '0;
                        r_go    <= 1'b1;
                        r_state <= S_SQ;
                    end else begin
                        r_m    <= {r_m[29:0], 1'b0};
                        r_kexp <= r_kexp - 5'd1;
                    end
                end
                S_SQ: begin
                    // square the mantissa; an overflow past 2.0 yields a fraction bit
                    if (mul_ready) begin
                        r_frac <= {r_frac[26:0], m2[31]};
                        r_m    <= m2[31] ? m2[31:1] : m2[30:0];
                        r_go   <= 1'b1;
                        if (r_it == 5'(ttc_pkg::LN_FRAC_BITS - 1)) begin
                            r_state <= S_SCALE;
                        end else begin
                            r_it <= r_it + 5'd1;
                        end
                    end
                end
                S_SCALE: begin
                    if (mul_ready) begin
                        case (r_sel)
                            2'd0: begin
                                r_ln_rs <= ln_new;
                                r_sel   <= 2'd1;
                                r_m     <= 31'(r_avg);
                                r_kexp  <= 5'd30;
                                r_state <= S_NORM;
                            end
                            2'd1: begin
                                r_ln_a  <= ln_new;
                                r_sel   <= 2'd2;
                                r_m     <= 31'(lnb_x);
                                r_kexp  <= 5'd30;
                                r_state <= S_NORM;
                            end
                            default: begin
                                r_l     <= l_new;
                                r_go    <= 1'b1;
                                r_state <= S_L2;
                            end
                        endcase
                    end
                end
                S_L2: begin
                    if (mul_ready) begin
                        r_l2    <= 64'(mul_p >>> 24);
                        r_go    <= 1'b1;
                        r_state <= S_L3;
                    end
                end
                S_L3: begin
                    if (mul_ready) begin
                        r_l3    <= 33'(mul_p >>> 32);
                        r_go    <= 1'b1;
                        r_state <= S_BL;
                    end
                end
                S_BL: begin
                    if (mul_ready) begin
                        r_y     <= a_term + 64'(mul_p >>> 16);
                        r_go    <= 1'b1;
                        r_state <= S_CL;
                    end
                end
                S_CL: begin
                    if (mul_ready) begin
                        r_y <= y_fin;
                        if (y_fin == 64'sd0) begin
                            // zero denominator: take the positive cap
                            r_k     <= $signed(ttc_pkg::K_CAP) + off128;
                            r_state <= S_UNIT;
                        end else begin
                            r_go    <= 1'b1;
                            r_state <= S_KDIV;
                        end
                    end
                end
                S_KDIV: begin
                    if (div_ready) begin
                        r_k     <= k_div;
                        r_state <= S_UNIT;
                    end
                end
                S_UNIT: begin
                    case (r_output_unit)
                        ttc_pkg::UNIT_CELSIUS: begin
                            r_t     <= c_t;
                            r_state <= S_OUT;
                        end
                        ttc_pkg::UNIT_FAHRENHEIT: begin
                            // floor division by five on the magnitude
                            r_fneg  <= f_q[63];
                            r_fq    <= f_q[63] ? (64'sd4 - f_q) : f_q;
                            r_go    <= 1'b1;
                            r_state <= S_FDIV;
                        end
                        default: begin
                            r_t     <= k_t;
                            r_state <= S_OUT;
                        end
                    endcase
                end
                S_FDIV: begin
                    if (div_ready) begin
                        r_t     <= r_fneg ? -$signed(r_dq) : $signed(r_dq);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_temp  <= r_fault ? 16'sd0 : t_sat;
                        r_out_avg   <= ttc_pkg::t_reading'(r_avg);
                        r_out_fault <= r_fault;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            // multiplier: add and shift one bit of B per cycle
            if (mul_start) begin
                r_ma    <= mag_a;
                r_mh    <= '0;
                r_ml    <= mag_b;
                r_mneg  <= mul_a[63] ^ mul_b[32];
                r_mcnt  <= '0;
                r_mbusy <= 1'b1;
                r_mdone <= 1'b0;
            end else if (r_mbusy) begin
                r_mh   <= m_sum[64:1];
                r_ml   <= {m_sum[0], r_ml[31:1]};
                r_mcnt <= r_mcnt + 5'd1;
                if (r_mcnt == '1) begin
                    r_mbusy <= 1'b0;
                    r_mdone <= 1'b1;
                end
            end else begin
                r_mdone <= 1'b0;
            end

            // divider: shift in one dividend bit, subtract when it fits
            if (div_start) begin
                r_dq    <= div_n;
                r_dr    <= '0;
                r_dd    <= div_d;
                r_dcnt  <= '0;
                r_dbusy <= 1'b1;
                r_ddone <= 1'b0;
            end else if (r_dbusy) begin
                r_dr   <= d_ge ? d_diff[63:0] : d_sh[63:0];
                r_dq   <= {r_dq[62:0], d_ge};
                r_dcnt <= r_dcnt + 6'd1;
                if (r_dcnt == '1) begin
                    r_dbusy <= 1'b0;
                    r_ddone <= 1'b1;
                end
            end else begin
                r_ddone <= 1'b0;
            end
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.temperature      = r_out_temp;
    assign o_out.averaged_reading = r_out_avg;
    assign o_out.fault            = r_out_fault;

`ifndef SYNTH
    // the two arithmetic units are never run at once
    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_mbusy && r_dbusy))
        else $error("multiplier and divider busy together");

    // the window count never passes the largest window
    a_window_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_taken <= CW'(MAX_WINDOW))
        else $error("sample count beyond window");

    // a faulted result carries a zero temperature
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.fault) |-> (o_out.temperature == 16'sd0))
        else $error("fault with nonzero temperature");

    // a finished product is only seen by a state that waits for one
    a_mul_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mdone |-> (r_state == S_SQ || r_state == S_SCALE || r_state == S_L2 ||
                     r_state == S_L3 || r_state == S_BL || r_state == S_CL))
        else $error("product finished outside a multiply step");
`endif

endmodule

/* verif/tb_thermistor_temperature_converter_top.sv */
`timescale 1ns / 1ps

module tb_thermistor_temperature_converter_top;

    typedef struct packed {
        ttc_pkg::t_temp    temperature;
        ttc_pkg::t_reading averaged_reading;
        logic              fault;
    } t_result;

    typedef enum logic { ROW_WRITE, ROW_SAMPLE } t_row_kind;

    // One directed step: a register write or a sample, with an optional
    // hand-typed expected reading for the sample that closes a window.
    typedef struct packed {
        t_row_kind   kind;
        logic [2:0]  reg_idx;
        logic [31:0] value;
        logic        typed;
        t_result     want;
    } t_row;

    typedef struct packed {
        logic    typed;
        t_result want;
    } t_stamp;

    localparam int SETTLE_CYCLES = 4000;   // covers one closing-sample latency
    localparam int HOLD_CYCLES   = 15000;  // long receiver hold-off
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 69;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ttc_in_if  adc_ch ();
    ttc_out_if temp_ch ();

    thermistor_temperature_converter_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (adc_ch),
        .o_out   (temp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the register file and of the averaging window
    logic [6:0]  cfg_count;
    logic [19:0] cfg_series;
    longint      cfg_a;
    longint      cfg_b;
    longint      cfg_c;
    logic        cfg_pull_up;
    longint      cfg_offset;
    logic [1:0]  cfg_unit;
    int unsigned win_sum;
    int unsigned win_taken;

    t_result  pending_readings [$];
    t_stamp   sample_stamps [$];
    int       mismatch_count;
    bit       hold_req;
    bit       tx_steady;
    bit       rx_steady;

    // Directed table, walked in order once reset is released
    t_row directed_rows [35] = '{
        '{ROW_WRITE,  ttc_pkg::REG_SAMPLE_COUNT, 32'd1,     1'b0, '0},
        '{ROW_SAMPLE, 3'd0,             32'd0,          1'b1, '{16'sd0, 10'd0, 1'b1}},
        '{ROW_SAMPLE, 3'd0,             32'd1,          1'b0, '0},
        '{ROW_SAMPLE, 3'd0,             32'd1023,       1'b0, '0},
        '{ROW_SAMPLE, 3'd0,             32'd512,        1'b0, '0},
        '{ROW_WRITE,  ttc_pkg::REG_OUTPUT_UNIT, 32'(ttc_pkg::UNIT_CELSIUS), 1'b0, '0},
        '{ROW_SAMPLE, 3'd0,             32'd300,        1'b0, '0},
        '{ROW_WRITE,  ttc_pkg::REG_OUTPUT_UNIT, 32'(ttc_pkg::UNIT_FAHRENHEIT), 1'b0, '0},
        '{ROW_SAMPLE, 3'd0,             32'd700,        1'b0, '0},
        '{ROW_WRITE,  ttc_pkg::REG_OUTPUT_UNIT, 32'd3,      1'b0, '0},
        '{ROW_SAMPLE, 3'd0,             32'd700,        1'b0, '0},
        '{ROW_WRITE,  ttc_pkg::REG_PULL_UP,     32'd0,      1'b0, '0},
        '{ROW_SAMPLE, 3'd0,             32'd1,          1'b0, '0},
        '{ROW_SAMPLE, 3'd0,             32'd1023,       1'b0, '0},
        '{ROW_WRITE,  ttc_pkg::REG_SERIES_RES,  32'd0,      1'b0, '0},
        '{ROW_SAMPLE, 3'd0,             32'd512,        1'b0, '0},
        '{ROW_WRITE,  ttc_pkg::REG_SERIES_RES,  32'hF_FFFF, 1'b0, '0},
        '{ROW_SAMPLE, 3'd0,             32'd512,        1'b0, '0},
        '{ROW_WRITE,  ttc_pkg::REG_TEMP_OFFSET, 32'd4095,   1'b0, '0},
        '{ROW_SAMPLE, 3'd0,             32'd400,        1'b0, '0},
        '{ROW_WRITE,  ttc_pkg::REG_TEMP_OFFSET, 32'h1000,   1'b0, '0},
        '{ROW_SAMPLE, 3'd0,             32'd400,        1'b0, '0},
        '{ROW_WRITE,  ttc_pkg::REG_COEFF_A,     32'd0,      1'b0, '0},
        '{ROW_WRITE,  ttc_pkg::REG_COEFF_B,     32'd0,      1'b0, '0},
        '{ROW_WRITE,  ttc_pkg::REG_COEFF_C,     32'd0,      1'b0, '0},
        // zero denominator: positive cap, saturates high
        '{ROW_SAMPLE, 3'd0,             32'd512,        1'b1, '{16'sd32767, 10'd512, 1'b0}},
        '{ROW_WRITE,  ttc_pkg::REG_COEFF_A,     32'h8000_0000, 1'b0, '0},
        // negative denominator: -2^20 Q11 kelvin plus the -4096/16 offset
        '{ROW_SAMPLE, 3'd0,             32'd512,        1'b1, '{-16'sd12288, 10'd512, 1'b0}},
        '{ROW_WRITE,  ttc_pkg::REG_SAMPLE_COUNT, 32'd0,     1'b0, '0},
        '{ROW_SAMPLE, 3'd0,             32'd5,          1'b0, '0},
        '{ROW_WRITE,  ttc_pkg::REG_SAMPLE_COUNT, 32'd3,     1'b0, '0},
        '{ROW_SAMPLE, 3'd0,             32'd10,         1'b0, '0},
        '{ROW_SAMPLE, 3'd0,             32'd20,         1'b0, '0},
        // shrink the window mid-way: the next sample closes it with three taken
        '{ROW_WRITE,  ttc_pkg::REG_SAMPLE_COUNT, 32'd1,     1'b0, '0},
        '{ROW_SAMPLE, 3'd0,             32'd30,         1'b0, '0}
    };

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Natural log in Q24 via bit-serial log2 with 28 fraction bits
    function automatic longint ln_q24(input int unsigned x);
        int unsigned       k;
        longint unsigned   m;
        longint unsigned   frac;
        k    = 0;
        frac = 0;
        while (k < 31 && (x >> (k + 1)) != 0)
            k++;
        m = 64'(x) << (30 - k);
        for (int i = 0; i < ttc_pkg::LN_FRAC_BITS; i++) begin
            m    = (m * m) >> 30;
            frac = frac << 1;
            if (m >= 64'h8000_0000) begin
                frac = frac | 64'd1;
                m    = m >> 1;
            end
        end
        return longint'((((64'(k) << 28) | frac) * 64'(ttc_pkg::LN2_Q30)) >> 34);
    endfunction

    function automatic longint floor_div(input longint x, input longint d);
        if (x >= 0)
            return x / d;
        return -((-x + d - 1) / d);
    endfunction

    // Steinhart-Hart kelvin in Q11 before the offset
    function automatic longint steinhart_kelvin(input int unsigned avg);
        int unsigned     rs;
        longint          ln_r;
        longint          l2;
        longint          l3;
        longint          denom;
        longint unsigned mag;
        rs   = (cfg_series != 0) ? int'(cfg_series) : 1;
        ln_r = cfg_pull_up ? ln_q24(rs) + ln_q24(avg) - ln_q24(1024 - avg)
                           : ln_q24(rs) - ln_q24(avg) + ln_q24(1024 - avg);
        l2    = (ln_r * ln_r) >>> 24;
        l3    = (l2 * ln_r) >>> 32;
        denom = cfg_a * 4096 + ((cfg_b * ln_r) >>> 16) + ((cfg_c * l3) >>> 28);
        if (denom == 0)
            return longint'(ttc_pkg::K_CAP);
        mag = ttc_pkg::DIV_TOP / longint'(denom > 0 ? denom : -denom);
        if (mag > ttc_pkg::K_CAP)
            mag = ttc_pkg::K_CAP;
        return denom > 0 ? longint'(mag) : -longint'(mag);
    endfunction

    // Add one sample to the window; returns 1 with the reading when it closes
    function automatic bit advance_window(input ttc_pkg::t_reading sample,
                                          output t_result r);
        int unsigned limit;
        int unsigned avg;
        longint      kel;
        longint      cel;
        longint      deg;
        limit = cfg_count;
        if (limit == 0)
            limit = 1;
        if (limit > 64)
            limit = 64;
        win_sum   += sample;
        win_taken += 1;
        r = '0;
        if (win_taken < limit)
            return 1'b0;
        avg       = win_sum / win_taken;
        win_sum   = 0;
        win_taken = 0;
        r.averaged_reading = avg[9:0];
        if (avg == 0) begin
            r.fault = 1'b1;
            return 1'b1;
        end
        kel = steinhart_kelvin(avg) + cfg_offset * 128;
        cel = kel - ttc_pkg::KELVIN_0C_Q11;
        case (cfg_unit)
            ttc_pkg::UNIT_CELSIUS:    deg = floor_div(cel + 64, 128);
            ttc_pkg::UNIT_FAHRENHEIT: deg = floor_div(cel * 9 + 327680 + 320, 640);
            default:                  deg = floor_div(kel + 64, 128);
        endcase
        if (deg > 32767)
            deg = 32767;
        if (deg < -32768)
            deg = -32768;
        r.temperature = deg[15:0];
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Clock, limit and initial drive
    // ------------------------------------------------------------------

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Generous ceiling: every sample closing a window, worst stalls both sides
    initial begin
        #40_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic void note_failure(input string what, input t_result want,
                                         input t_result got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s: exp temp=%0d avg=%0d fault=%0b, got temp=%0d avg=%0d fault=%0b",
                     what, want.temperature, want.averaged_reading, want.fault,
                     got.temperature, got.averaged_reading, got.fault);
    endfunction

    // ------------------------------------------------------------------
    // Monitors: predict on each sample transfer, check each reading transfer
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_stamp   stamp;
        t_result  predicted;
        if (i_rst_n && adc_ch.valid && adc_ch.ready) begin
            stamp = sample_stamps.pop_front();
            if (advance_window(adc_ch.adc_sample, predicted))
                pending_readings.push_back(stamp.typed ? stamp.want : predicted);
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && temp_ch.valid && temp_ch.ready) begin
            got = '{temp_ch.temperature, temp_ch.averaged_reading, temp_ch.fault};
            if (pending_readings.size() == 0) begin
                note_failure("unexpected reading", '0, got);
            end else begin
                want = pending_readings.pop_front();
                if (got.fault !== want.fault
                        || got.averaged_reading !== want.averaged_reading
                        || got.temperature !== want.temperature)
                    note_failure("reading mismatch", want, got);
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random hold-offs, one long hold when asked
    // ------------------------------------------------------------------

    initial begin
        int gap;
        temp_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                // hold off long enough for the block to back up its input
                hold_req = 1'b0;
                temp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                gap = rx_steady ? 0 : $urandom_range(0, 11);
                if (gap > 0) begin
                    temp_ch.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            temp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!temp_ch.valid);
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one sample, return at the edge of its transfer with valid still high
    task automatic send_sample(input ttc_pkg::t_reading sample, input logic typed,
                               input t_result want);
        int     gap;
        t_stamp stamp;
        gap         = tx_steady ? 0 : $urandom_range(0, 11);
        stamp.typed = typed;
        stamp.want  = want;
        sample_stamps.push_back(stamp);
        if (gap > 0) begin
            adc_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        adc_ch.valid      <= 1'b1;
        adc_ch.adc_sample <= sample;
        do @(posedge i_clk); while (!adc_ch.ready);
    endtask

    // Drop valid, drain every pending reading, then let the pipeline settle
    task automatic drain_and_settle();
        adc_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_readings.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup, access, idle; mirror into the shadow registers
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            ttc_pkg::REG_SAMPLE_COUNT: cfg_count   = value[6:0];
            ttc_pkg::REG_SERIES_RES:   cfg_series  = value[19:0];
            ttc_pkg::REG_COEFF_A:      cfg_a       = longint'(signed'(value));
            ttc_pkg::REG_COEFF_B:      cfg_b       = longint'(signed'(value));
            ttc_pkg::REG_COEFF_C:      cfg_c       = longint'(signed'(value));
            ttc_pkg::REG_PULL_UP:      cfg_pull_up = value[0];
            ttc_pkg::REG_TEMP_OFFSET:  cfg_offset  = longint'(signed'(value[12:0]));
            ttc_pkg::REG_OUTPUT_UNIT:  cfg_unit    = value[1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Coefficient near its default, or anywhere in range now and then
    function automatic logic [31:0] pick_coeff(input logic [31:0] nominal);
        if ($urandom_range(0, 4) == 0)
            return $urandom();
        return nominal + $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
    endfunction

    function automatic ttc_pkg::t_reading pick_sample();
        case ($urandom_range(0, 9))
            0:       return 10'd0;
            1:       return ttc_pkg::t_reading'($urandom_range(0, 3));
            2:       return 10'd1023;
            default: return ttc_pkg::t_reading'($urandom_range(0, 1023));
        endcase
    endfunction

    task automatic configure_phase(input int phase);
        logic [31:0] count;
        logic [31:0] series;
        logic [31:0] offset;
        case (phase)
            0:       count = 32'd127;     // clamps to the largest window
            1:       count = 32'd64;
            2:       count = 32'd1;       // backpressure phase
            default: count = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom_range(1, 8);
        endcase
        case ($urandom_range(0, 4))
            0:       series = 32'd1;
            1:       series = 32'hF_FFFF;
            2:       series = 32'd10000;
            default: series = $urandom_range(0, 32'hF_FFFF);
        endcase
        case ($urandom_range(0, 3))
            0:       offset = 32'h0FFF;
            1:       offset = 32'h1000;
            default: offset = $urandom_range(0, 32'h1FFF);
        endcase
        write_reg(ttc_pkg::REG_SAMPLE_COUNT, count);
        write_reg(ttc_pkg::REG_SERIES_RES, series);
        write_reg(ttc_pkg::REG_COEFF_A, pick_coeff(32'd1232407859));
        write_reg(ttc_pkg::REG_COEFF_B, pick_coeff(32'd1035025163));
        write_reg(ttc_pkg::REG_COEFF_C, pick_coeff(32'd1028916));
        write_reg(ttc_pkg::REG_PULL_UP, $urandom_range(0, 1));
        write_reg(ttc_pkg::REG_TEMP_OFFSET, offset);
        write_reg(ttc_pkg::REG_OUTPUT_UNIT, $urandom_range(0, 3));
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        // Start from the block's reset values
        cfg_count      = 7'd8;
        cfg_series     = 20'd10000;
        cfg_a          = 1232407859;
        cfg_b          = 1035025163;
        cfg_c          = 1028916;
        cfg_pull_up    = 1'b1;
        cfg_offset     = 0;
        cfg_unit       = ttc_pkg::UNIT_KELVIN;
        win_sum        = 0;
        win_taken      = 0;
        mismatch_count = 0;
        hold_req       = 1'b0;
        tx_steady      = 1'b0;
        rx_steady      = 1'b0;

        i_rst_n           <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        adc_ch.valid      <= 1'b0;
        adc_ch.adc_sample <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: drain before every register write
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_WRITE) begin
                drain_and_settle();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
            end else begin
                send_sample(directed_rows[i].value[9:0], directed_rows[i].typed,
                            directed_rows[i].want);
            end
        end

        // Random phases, each with a fresh register set
        for (int phase = 0; phase < PHASES; phase++) begin
            drain_and_settle();
            configure_phase(phase);
            tx_steady = (phase == 2) || ($urandom_range(0, 3) == 0);
            rx_steady = (phase != 2) && ($urandom_range(0, 3) == 0);
            if (phase == 2)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_sample(pick_sample(), 1'b0, '0);
        end

        // Wait out the tail, then count anything still owed as a failure
        adc_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_readings.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_readings.size() != 0)
            mismatch_count++;

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/ttc_pkg.sv
rtl/ttc_channels.sv
rtl/thermistor_temperature_converter_top.sv
verif/tb_thermistor_temperature_converter_top.sv
